[hw/rtl/pfla_pkg.sv]
package pfla_pkg;

	localparam int MAX_PAGES     = 1024;
	localparam int INITIAL_PAGES = 16;

	localparam int INIT_COUNT   = (INITIAL_PAGES > MAX_PAGES) ? MAX_PAGES : INITIAL_PAGES;
	localparam int PAGE_W       = $clog2(MAX_PAGES);
	localparam int COUNT_W      = PAGE_W + 1;
	localparam int PAGE_FIELD_W = 10;
	localparam int CMP_W        = (COUNT_W > PAGE_FIELD_W) ? COUNT_W : PAGE_FIELD_W;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD_PAGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_GROW,
		S_RELOAD,
		S_POP,
		S_DONE
	} fsm_state_t;

endpackage

[hw/rtl/pfla_ram.sv]
module pfla_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[hw/rtl/page_free_list_allocator.sv]
// Channel   Signals                                   Direction
// request   req_valid, req_stall, command,            in (stall out)
//           page_number
// response  rsp_valid, rsp_stall, allocated_page,     out (stall in)
//           status
//
// One request is handled at a time. An allocate that finds the list empty
// and can still double the pool first walks the new pages through the single
// write port of the link store, one page per cycle, then waits in a reload state.
// After reset the block writes the initial links, one per cycle for
// min(INITIAL_PAGES, MAX_PAGES) pages, and stalls requests meanwhile.
// A stalled response is held in its register while the next request is taken.
module page_free_list_allocator
	import pfla_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic                    command,
	input  logic [PAGE_FIELD_W-1:0] page_number,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [PAGE_FIELD_W-1:0] allocated_page,
	output logic [1:0]              status
);

	fsm_state_t state_q, state_next;

	logic [PAGE_W-1:0]       free_head_q;
	logic [COUNT_W-1:0]      page_count_q;
	logic [PAGE_W-1:0]       walk_q;
	logic [PAGE_W-1:0]       res_page_q;
	status_t                 res_status_q;
	logic                    rsp_valid_q;
	logic [PAGE_FIELD_W-1:0] rsp_page_q;
	status_t                 rsp_status_q;

	logic [PAGE_W-1:0]  rd_data;
	logic               wr_en;
	logic [PAGE_W-1:0]  wr_addr;
	logic [PAGE_W-1:0]  wr_data;
	logic               req_fire;
	logic               slot_free;
	logic               free_ok;
	logic               grow_ok;
	logic               walk_end;
	logic [PAGE_W-1:0]  walk_low;
	logic [COUNT_W:0]   grown;
	logic [PAGE_W-1:0]  grow_top;
	logic [CMP_W-1:0]   page_wide;
	logic [CMP_W-1:0]   count_wide;

	assign req_fire   = req_valid && !req_stall;
	assign slot_free  = !rsp_valid_q || !rsp_stall;
	assign grown      = {page_count_q, 1'b0};
	assign grow_ok    = grown <= (COUNT_W + 1)'(MAX_PAGES);
	assign grow_top   = PAGE_W'(grown - 1'b1);
	assign page_wide  = CMP_W'(page_number);
	assign count_wide = CMP_W'(page_count_q);
	assign free_ok    = (page_wide != '0) && (page_wide < count_wide);
	assign walk_low   = (state_q == S_INIT) ? '0 : page_count_q[PAGE_W-1:0];
	assign walk_end   = walk_q == walk_low;

	pfla_ram #(
		.WIDTH(PAGE_W),
		.DEPTH(MAX_PAGES)
	) u_link_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(free_head_q),
		.rd_data(rd_data)
	);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_INIT: begin
				if (walk_end) state_next = S_IDLE;
			end
			S_IDLE: begin
				if (req_fire) begin
					if (command == CMD_FREE) state_next = S_DONE;
					else if (free_head_q != '0) state_next = S_POP;
					else if (grow_ok) state_next = S_GROW;
					else state_next = S_DONE;
				end
			end
			S_GROW: begin
				if (walk_end) state_next = S_RELOAD;
			end
			S_RELOAD: state_next = S_POP;
			S_POP:    state_next = S_DONE;
			S_DONE: begin
				if (slot_free) state_next = S_IDLE;
			end
			default:  state_next = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = state_q != S_IDLE;
		wr_en     = 1'b0;
		wr_addr   = walk_q;
		wr_data   = walk_end ? '0 : walk_q - 1'b1;
		unique case (state_q)
			S_INIT, S_GROW: wr_en = 1'b1;
			S_IDLE: begin
				if (req_fire && command == CMD_FREE && free_ok) begin
					wr_en   = 1'b1;
					wr_addr = PAGE_W'(page_number);
					wr_data = free_head_q;
				end
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			free_head_q  <= PAGE_W'(INIT_COUNT - 1);
			page_count_q <= COUNT_W'(INIT_COUNT);
			walk_q       <= PAGE_W'(INIT_COUNT - 1);
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == S_INIT || state_q == S_GROW) begin
				walk_q <= walk_q - 1'b1;
			end
			if (state_q == S_GROW && walk_end) begin
				free_head_q  <= grow_top;
				page_count_q <= grown[COUNT_W-1:0];
			end
			if (state_q == S_IDLE && req_fire) begin
				res_page_q <= '0;
				if (command == CMD_FREE) begin
					res_status_q <= free_ok ? ST_OK : ST_BAD_PAGE;
					if (free_ok) free_head_q <= PAGE_W'(page_number);
				end else if (free_head_q == '0 && !grow_ok) begin
					res_status_q <= ST_NO_SPACE;
				end else begin
					res_status_q <= ST_OK;
					walk_q       <= grow_top;
				end
			end
			if (state_q == S_POP) begin
				res_page_q  <= free_head_q;
				free_head_q <= rd_data;
			end
			if (state_q == S_DONE && slot_free) begin
				rsp_valid_q  <= 1'b1;
				rsp_page_q   <= PAGE_FIELD_W'(res_page_q);
				rsp_status_q <= res_status_q;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign allocated_page = rsp_page_q;
	assign status         = rsp_status_q;

	// A failed request never hands out a page.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q != ST_OK |-> rsp_page_q == '0)
		else $error("page handed out with an error status");

	// Between requests the head always names a page inside the current count.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> CMP_W'(free_head_q) < count_wide)
		else $error("free list head beyond page count");

	// The count never grows past the maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		page_count_q <= COUNT_W'(MAX_PAGES))
		else $error("page count above maximum");

	// A new response only comes out of the completion state.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !$past(rsp_valid_q && rsp_stall) |-> $past(state_q == S_DONE))
		else $error("response without a completed request");

endmodule

[bench/page_free_list_allocator_tb.sv]
`timescale 1ns / 1ps

module page_free_list_allocator_tb;
	import pfla_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int CALM_TAIL  = 80;
	localparam int FULL_GOAL  = 6;

	typedef struct {
		command_t                cmd;
		logic [PAGE_FIELD_W-1:0] page;
		logic [PAGE_FIELD_W-1:0] want_page;
		status_t                 want_status;
		bit                      drain;
	} page_req_t;

	typedef struct {
		logic [PAGE_FIELD_W-1:0] page;
		status_t                 status;
	} page_rsp_t;

	logic                    clk;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_stall;
	logic                    command;
	logic [PAGE_FIELD_W-1:0] page_number;
	logic                    rsp_valid;
	logic                    rsp_stall;
	logic [PAGE_FIELD_W-1:0] allocated_page;
	logic [1:0]              status;

	page_req_t pending [$];
	page_rsp_t results_due [$];
	page_req_t cur;
	int        held [$];
	bit        lent [MAX_PAGES];
	int        pool_head;
	int        pool_count;
	int        pool_link [MAX_PAGES];
	bit        drain_next;
	int        full_hits;
	int        mismatches;
	int        idle_cycles;
	int        req_gap;
	int        rsp_hold;
	bit        req_taken;

	page_free_list_allocator u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.command        (command),
		.page_number    (page_number),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.allocated_page (allocated_page),
		.status         (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic page_rsp_t serve_request(command_t cmd, int pg);
		page_rsp_t r;
		int        grown;
		r.page = '0;
		r.status = ST_OK;
		if (cmd == CMD_ALLOC) begin
			if (pool_head == 0) begin
				grown = 2 * pool_count;
				if (grown > MAX_PAGES) begin
					r.status = ST_NO_SPACE;
				end else begin
					for (int i = grown - 1; i > pool_count; i--)
						pool_link[i] = i - 1;
					pool_link[pool_count] = 0;
					pool_head = grown - 1;
					pool_count = grown;
				end
			end
			if (r.status == ST_OK) begin
				r.page = PAGE_FIELD_W'(pool_head);
				pool_head = pool_link[pool_head];
			end
		end else if (pg == 0 || pg >= pool_count) begin
			r.status = ST_BAD_PAGE;
		end else begin
			pool_link[pg] = pool_head;
			pool_head = pg;
		end
		return r;
	endfunction

	task automatic plan(command_t cmd, int pg);
		page_req_t q;
		page_rsp_t r;
		r = serve_request(cmd, pg);
		q.cmd = cmd;
		q.page = PAGE_FIELD_W'(pg);
		q.want_page = r.page;
		q.want_status = r.status;
		q.drain = drain_next;
		drain_next = 1'b0;
		pending.insert(pending.size(), q);
		if (cmd == CMD_ALLOC && r.status == ST_OK) begin
			held.insert(held.size(), int'(r.page));
			lent[r.page] = 1'b1;
		end
		if (r.status == ST_NO_SPACE)
			full_hits++;
	endtask

	task automatic free_page(int pg);
		for (int i = 0; i < held.size(); i++) begin
			if (held[i] == pg) begin
				held.delete(i);
				break;
			end
		end
		lent[pg] = 1'b0;
		plan(CMD_FREE, pg);
	endtask

	// Requests change only after the previous one was taken; idle bursts stop
	// near the end of the run.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (pending.size() == 0) begin
				req_valid <= 1'b0;
			end else if (pending[0].drain && results_due.size() != 0) begin
				req_valid <= 1'b0;
			end else if (pending.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				req_gap = $urandom_range(0, 14);
				req_valid <= 1'b0;
			end else begin
				cur = pending.pop_front();
				req_valid <= 1'b1;
				command <= cur.cmd;
				page_number <= cur.page;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || pending.size() <= CALM_TAIL) begin
			rsp_stall <= 1'b0;
		end else if (rsp_hold > 0) begin
			rsp_hold--;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			rsp_hold = $urandom_range(0, 14);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_valid && !req_stall;
			if (rsp_valid && !rsp_stall) begin
				if (results_due.size() == 0) begin
					$display("%0t: response with nothing expected: page %0d status %0d",
						$time, allocated_page, status);
					mismatches++;
				end else begin
					if (allocated_page !== results_due[0].page) begin
						$display("%0t: allocated_page mismatch: expected %0d, actual %0d",
							$time, results_due[0].page, allocated_page);
						mismatches++;
					end
					if (status !== results_due[0].status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, results_due[0].status, status);
						mismatches++;
					end
					void'(results_due.pop_front());
				end
			end
			if (req_valid && !req_stall)
				results_due.insert(results_due.size(),
					page_rsp_t'{cur.want_page, cur.want_status});
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int r;
		int alloc_pct;
		int pg;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		command = CMD_ALLOC;
		page_number = '0;
		rsp_stall = 1'b0;
		req_taken = 1'b0;
		req_gap = 0;
		rsp_hold = 0;
		idle_cycles = 0;
		mismatches = 0;
		full_hits = 0;
		drain_next = 1'b0;

		pool_count = INIT_COUNT;
		pool_head = INIT_COUNT - 1;
		for (int i = 0; i < MAX_PAGES; i++) begin
			pool_link[i] = (i < INIT_COUNT && i > 0) ? i - 1 : 0;
			lent[i] = 1'b0;
		end

		// Bad frees, draining the initial list, growth, and reuse of pages.
		plan(CMD_FREE, 0);
		plan(CMD_FREE, 1023);
		plan(CMD_FREE, INIT_COUNT);
		repeat (INIT_COUNT - 1) plan(CMD_ALLOC, 0);
		plan(CMD_ALLOC, 0);
		free_page(INIT_COUNT - 1);
		free_page(2 * INIT_COUNT - 1);
		plan(CMD_ALLOC, 0);
		plan(CMD_ALLOC, 1023);
		plan(CMD_FREE, 2 * INIT_COUNT);
		free_page(1);

		// Mostly allocation bursts until FULL_GOAL allocations were refused, then a balanced mix.
		drain_next = 1'b1;
		while (pending.size() < 600) begin
			r = $urandom_range(0, 99);
			alloc_pct = (full_hits < FULL_GOAL) ? 75 : 40;
			if (r < alloc_pct) begin
				repeat ($urandom_range(1, 48)) plan(CMD_ALLOC, $urandom_range(0, 1023));
			end else if (r < 92) begin
				repeat ($urandom_range(1, 16)) begin
					if (held.size() != 0)
						free_page(held[$urandom_range(0, held.size() - 1)]);
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					pg = $urandom_range(1, pool_count - 1);
					if (full_hits >= FULL_GOAL && !lent[pg] && $urandom_range(0, 3) == 0)
						plan(CMD_FREE, pg);
					else if (pool_count >= 1024 || $urandom_range(0, 3) == 0)
						plan(CMD_FREE, 0);
					else
						plan(CMD_FREE, $urandom_range(pool_count, 1023));
				end
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || req_valid) @(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
